// File: design/pll_word_ramp_with_divider_recalc_core_macros.svh
// Assertion macros shared by the PLL word ramp block.
// Depends on nothing; included by the top level.
`ifndef PLL_WORD_RAMP_WITH_DIVIDER_RECALC_CORE_MACROS_SVH
`define PLL_WORD_RAMP_WITH_DIVIDER_RECALC_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define PWR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PWR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/pwr_pkg.sv
// Package for the PLL word ramp block: payload types, codes and constants.
// Depends on nothing.
`timescale 1ns / 1ps
package pwr_pkg;

  localparam int unsigned WordW = 25;
  localparam int unsigned FreqW = 24;

  localparam logic [1:0] ActRequest = 2'd0;
  localparam logic [1:0] ActTick    = 2'd1;
  localparam logic [1:0] ActPreload = 2'd2;

  localparam logic [2:0] StAccepted = 3'd0;
  localparam logic [2:0] StRefused  = 3'd1;
  localparam logic [2:0] StBusy     = 3'd2;
  localparam logic [2:0] StStep     = 3'd3;
  localparam logic [2:0] StLast     = 3'd4;
  localparam logic [2:0] StAborted  = 3'd5;

  localparam logic RegStepInterval = 1'b0;
  localparam logic RegGuardWord    = 1'b1;

  localparam logic [15:0]      StepIntervalReset = 16'd100;
  localparam logic [WordW-1:0] GuardWordReset    = 25'h0050180;

  localparam logic [FreqW-1:0] DivPeriph  = 24'd133120;
  localparam logic [FreqW-1:0] DivDisplay = 24'd159744;
  localparam logic [FreqW-1:0] DivSerial  = 24'd99840;
  localparam logic [FreqW-1:0] DivHdmi    = 24'd66560;
  localparam logic [FreqW-1:0] DivVideo   = 24'd399360;

  typedef struct packed {
    logic [1:0]       action;
    logic [WordW-1:0] target_word;
    logic             display_clock_on;
    logic             sd_clock_on;
  } pwr_in_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [WordW-1:0] pll_word;
    logic [FreqW-1:0] freq_khz;
    logic [3:0]       periph_div;
    logic [3:0]       display_div;
    logic [3:0]       serial_rx_div;
    logic [3:0]       hdmi_div;
    logic [3:0]       video_div;
    logic [3:0]       sd_div;
  } pwr_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_DIV, S_QUOT, S_OUT
  } pwr_state_e;

  typedef struct packed {
    logic load;      // capture input item
    logic decide;    // evaluate item, update state
    logic div_start;
    logic quot_step; // one step of the quotient engine
    logic present;   // result register valid
  } pwr_cmd_t;

  typedef struct packed {
    logic has_result;
    logic need_div;
    logic div_done;
    logic quot_done;
  } pwr_sts_t;

  // Clamp a quotient to the 4-bit divider field.
  function automatic logic [3:0] clamp15(input logic [FreqW-1:0] q);
    logic [3:0] r;
    r = (q > 24'd15) ? 4'd15 : q[3:0];
    return r;
  endfunction

endpackage

// File: design/pwr_ctrl.sv
// Controller state machine of the PLL word ramp block.
// Depends on pwr_pkg.
`timescale 1ns / 1ps
module pwr_ctrl import pwr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_fire_i,
  input  logic     out_fire_i,
  input  pwr_sts_t sts_i,
  output pwr_cmd_t cmd_o,
  output logic     busy_o
);

  pwr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_fire_i) state_d = S_DECIDE;
      S_DECIDE: begin
        if (!sts_i.has_result) state_d = S_IDLE;
        else if (sts_i.need_div) state_d = S_DIV;
        else state_d = S_OUT;
      end
      S_DIV:    if (sts_i.div_done) state_d = S_QUOT;
      S_QUOT:   if (sts_i.quot_done) state_d = S_OUT;
      S_OUT:    if (out_fire_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load = in_fire_i;
      end
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        cmd_o.div_start = sts_i.has_result && sts_i.need_div;
      end
      S_DIV:  ;
      S_QUOT: cmd_o.quot_step = 1'b1;
      S_OUT:  cmd_o.present = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: design/pwr_datapath.sv
// Datapath of the PLL word ramp block: ramp state, serial divider, dividers.
// Depends on pwr_pkg.
`timescale 1ns / 1ps
module pwr_datapath import pwr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pwr_cmd_t         cmd_i,
  input  pwr_in_t          item_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [WordW-1:0] cfg_data_i,
  output pwr_sts_t         sts_o,
  output pwr_out_t         res_o
);

  logic [15:0]      step_interval_q;
  logic [WordW-1:0] guard_q;
  logic [WordW-1:0] cur_q, goal_q, origin_q, resume_q, next_q;
  logic             ramping_q;
  logic [15:0]      wait_q;
  pwr_in_t          it_q;
  pwr_out_t         res_q, res_d;
  logic             has_res_q, need_div_q;

  // Restoring divider: dividend mul*38400 (24 bits) by an 8-bit divider.
  logic [FreqW-1:0] dvd_q;
  logic [8:0]       rem_q;
  logic [7:0]       dvs_q;
  logic [4:0]       dcnt_q;
  logic             dbusy_q, half_q;
  logic             dfin_q;
  logic [9:0]       rem_sh;
  logic [FreqW-1:0] freq_w;

  // Quotient engine: repeated subtraction per divider, at most 15 steps.
  logic [FreqW-1:0] f_q;
  logic [FreqW-1:0] acc_q [6];
  logic [3:0]       cnt_q [6];
  logic [3:0]       qcnt_q;

  localparam logic [FreqW-1:0] Bases [6] = '{DivPeriph, DivDisplay, DivSerial,
                                              DivHdmi, DivVideo, DivSerial};

  logic             up, past, at_guard;
  logic [15:0]      wait_dec;

  always_comb begin
    up       = goal_q > origin_q;
    past     = (up && next_q > goal_q) || (!up && next_q < goal_q);
    at_guard = (next_q == guard_q) && (it_q.display_clock_on || it_q.sd_clock_on);
    wait_dec = wait_q - 16'd1;
    rem_sh   = {rem_q, dvd_q[FreqW-1]};
    freq_w   = half_q ? {1'b0, dvd_q[FreqW-1:1]} : dvd_q;
  end

  always_comb begin
    res_d = '0;
    res_d.pll_word = cur_q;
    case (it_q.action)
      ActRequest: begin
        if (ramping_q) res_d.status = StBusy;
        else if (it_q.sd_clock_on || (it_q.display_clock_on && it_q.target_word >= guard_q))
          res_d.status = StRefused;
        else res_d.status = StAccepted;
      end
      default: begin
        if (past) res_d.status = StLast;
        else if (at_guard) res_d.status = StAborted;
        else begin
          res_d.pll_word = next_q;
          res_d.status = (next_q == goal_q) ? StLast : StStep;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_interval_q <= StepIntervalReset;
      guard_q   <= GuardWordReset;
      cur_q     <= '0;
      goal_q    <= '0;
      origin_q  <= '0;
      resume_q  <= '0;
      next_q    <= '0;
      ramping_q <= 1'b0;
      wait_q    <= '0;
      has_res_q <= 1'b0;
      need_div_q <= 1'b0;
      dbusy_q   <= 1'b0;
      dcnt_q    <= '0;
      dfin_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegStepInterval) step_interval_q <= cfg_data_i[15:0];
        else guard_q <= cfg_data_i;
      end
      has_res_q <= 1'b0;
      need_div_q <= 1'b0;
      if (cmd_i.load) begin
        case (item_i.action)
          ActPreload: cur_q <= item_i.target_word;
          ActRequest: begin
            has_res_q <= 1'b1;
            need_div_q <= 1'b1;
          end
          ActTick: begin
            if (ramping_q) begin
              if (wait_q == 16'd0 || wait_dec == 16'd0) begin
                has_res_q <= 1'b1;
                wait_q <= '0;
              end else begin
                wait_q <= wait_dec;
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.decide && has_res_q) begin
        if (it_q.action == ActRequest) begin
          if (res_d.status == StAccepted) begin
            goal_q    <= it_q.target_word;
            origin_q  <= cur_q;
            next_q    <= (resume_q != '0) ? resume_q : cur_q;
            ramping_q <= 1'b1;
            wait_q    <= '0;
          end
        end else if (past) begin
          ramping_q <= 1'b0;
          resume_q  <= '0;
        end else if (at_guard) begin
          resume_q  <= next_q;
          ramping_q <= 1'b0;
        end else begin
          cur_q <= next_q;
          if (next_q == goal_q) begin
            ramping_q <= 1'b0;
            resume_q  <= '0;
          end else begin
            next_q <= up ? next_q + 1'b1 : next_q - 1'b1;
            wait_q <= step_interval_q;
          end
        end
      end
      // One-cycle flag in the cycle after the last divider step.
      dfin_q <= dbusy_q && (dcnt_q == 5'(FreqW - 1));
      if (cmd_i.div_start) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= '0;
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 5'd1;
        if (dcnt_q == 5'(FreqW - 1)) dbusy_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= item_i;
    if (cmd_i.decide) res_q <= res_d;
    if (cmd_i.div_start) begin
      dvd_q  <= 24'(it_q.target_word[7:0] * 16'd38400);
      dvs_q  <= it_q.target_word[23:16];
      half_q <= it_q.target_word[24];
      rem_q  <= '0;
    end else if (dbusy_q) begin
      if (rem_sh >= {2'b0, dvs_q}) begin
        rem_q <= 9'(rem_sh - {2'b0, dvs_q});
        dvd_q <= {dvd_q[FreqW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[8:0];
        dvd_q <= {dvd_q[FreqW-2:0], 1'b0};
      end
      if (dcnt_q == 5'(FreqW - 1)) begin
        qcnt_q <= '0;
      end
    end
    if (sts_o.div_done) begin
      f_q <= (dvs_q == '0) ? '0 : freq_w;
      for (int i = 0; i < 6; i++) begin
        acc_q[i] <= (dvs_q == '0) ? '0 : freq_w;
        cnt_q[i] <= '0;
      end
      qcnt_q <= '0;
    end else if (cmd_i.quot_step) begin
      qcnt_q <= qcnt_q + 4'd1;
      for (int i = 0; i < 6; i++) begin
        if (acc_q[i] >= Bases[i] && cnt_q[i] != 4'd15) begin
          acc_q[i] <= acc_q[i] - Bases[i];
          cnt_q[i] <= cnt_q[i] + 4'd1;
        end
      end
    end
    if (cmd_i.quot_step && sts_o.quot_done && res_q.status == StAccepted) begin
      res_q.freq_khz      <= f_q;
      res_q.periph_div    <= cnt_q[0];
      res_q.display_div   <= cnt_q[1];
      res_q.serial_rx_div <= cnt_q[2];
      res_q.hdmi_div      <= cnt_q[3];
      res_q.video_div     <= clamp15(24'(cnt_q[4]) + ((acc_q[4] != '0) ? 24'd1 : 24'd0));
      res_q.sd_div        <= cnt_q[5];
    end
  end

  always_comb begin
    sts_o.has_result = has_res_q;
    sts_o.need_div   = need_div_q;
    sts_o.div_done   = dfin_q;
    sts_o.quot_done  = (qcnt_q == 4'd15);
    res_o = res_q;
  end

endmodule

// File: design/pll_word_ramp_with_divider_recalc_core.sv
// Top level of the PLL word ramp block with divider recalculation.
// Depends on pwr_pkg, pwr_ctrl, pwr_datapath and the assertion macro header.
//
//  Channel   Direction  Handshake          Payload
//  in        in         in_valid/in_stall  pwr_in_t
//  out       out        out_valid/out_stall pwr_out_t
//  cfg       in         cfg_valid/cfg_ready index, data
//
// An item is taken in one cycle and evaluated in the next. A tick result is
// registered in the decide state and offered from the output state. Every
// request, busy and refused ones too, runs a 24-step shift-subtract divider
// and then the quotient engine before its result is offered. One item is in
// flight at a time. Reset is asynchronous and active low; it clears the ramp
// state and restores the register defaults. A stalled result holds in the
// output register until taken.
`timescale 1ns / 1ps
`include "pll_word_ramp_with_divider_recalc_core_macros.svh"
module pll_word_ramp_with_divider_recalc_core import pwr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  pwr_in_t     in_data_i,
  output logic        out_valid,
  input  logic        out_stall,
  output pwr_out_t    out_data_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  pwr_cmd_t cmd;
  pwr_sts_t sts;
  logic     busy;
  logic     in_fire, out_fire;

  // Input is taken only when the controller is idle.
  assign in_stall  = busy;
  assign in_fire   = in_valid && !busy;
  assign out_valid = cmd.present;
  assign out_fire  = out_valid && !out_stall;
  // Registers are always writable; writes are to be made only while the block idles; the block does not enforce it.
  assign cfg_ready = 1'b1;

  pwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_fire_i (out_fire),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  pwr_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .item_i     (in_data_i),
    .cfg_we_i   (cfg_valid && cfg_ready),
    .cfg_idx_i  (cfg_index_i[0]),
    .cfg_data_i (cfg_data_i[WordW-1:0]),
    .sts_o      (sts),
    .res_o      (out_data_o)
  );

  // A new item is never taken while a result is still offered.
  `PWR_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_valid, in_stall)
  // A stalled result stays offered in the next cycle.
  `PWR_ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && out_stall, out_valid)
  // Status codes stay within the defined set.
  `PWR_ASSERT_IMP(a_status, clk_i, rst_ni, out_valid, out_data_o.status <= StAborted)

endmodule

// File: dv/pll_word_ramp_with_divider_recalc_core_test.sv
// Self-checking testbench for the PLL word ramp block with divider recalculation.
// Depends on pwr_pkg and the top level pll_word_ramp_with_divider_recalc_core.
// A directed table runs first, then random ramp traffic checked by a local predictor.
`timescale 1ns / 1ps
module pll_word_ramp_with_divider_recalc_core_test;
  import pwr_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 100;
  localparam logic [1:0] ActUnknown = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pwr_in_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pwr_out_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  pll_word_ramp_with_divider_recalc_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predictor state: a private copy of the ramp registers and configuration.
  logic [15:0]      interval_q;
  logic [WordW-1:0] guard_q;
  logic [WordW-1:0] word_q, goal_q, origin_q, resume_q, next_q;
  logic             ramping_q;
  logic [15:0]      wait_q;

  pwr_out_t expected_results[$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit quiet = 1'b0;        // no idling in the last part of the run
  bit hold_off = 1'b0;     // long receiver stall requested by the stimulus
  bit stim_done = 1'b0;

  // Target frequency in kHz from the multiplier, divider and half bit.
  function automatic logic [FreqW-1:0] target_khz(input logic [WordW-1:0] w);
    logic [31:0] f;
    if (w[23:16] == 8'd0) return '0;
    f = (32'(w[7:0]) * 32'd38400) / 32'(w[23:16]);
    if (w[24]) f = f / 2;
    return f[FreqW-1:0];
  endfunction

  function automatic logic [3:0] sat_div(input logic [31:0] q);
    return (q > 32'd15) ? 4'd15 : q[3:0];
  endfunction

  // Advance the predicted ramp by one transaction; push any result it yields.
  task automatic predict_ramp(input pwr_in_t it);
    pwr_out_t r;
    logic [31:0] f;
    bit up;
    r = '0;
    r.pll_word = word_q;
    case (it.action)
      ActPreload: begin
        word_q = it.target_word;
      end
      ActRequest: begin
        if (ramping_q) begin
          r.status = StBusy;
          expected_results.push_back(r);
        end else if (it.sd_clock_on || (it.display_clock_on && it.target_word >= guard_q)) begin
          r.status = StRefused;
          expected_results.push_back(r);
        end else begin
          f = 32'(target_khz(it.target_word));
          goal_q = it.target_word;
          origin_q = word_q;
          next_q = (resume_q != '0) ? resume_q : word_q;
          ramping_q = 1'b1;
          wait_q = '0;
          r.status = StAccepted;
          r.freq_khz = f[FreqW-1:0];
          r.periph_div = sat_div(f / 133120);
          r.display_div = sat_div(f / 159744);
          r.serial_rx_div = sat_div(f / 99840);
          r.hdmi_div = sat_div(f / 66560);
          r.video_div = sat_div((f + 399359) / 399360);
          r.sd_div = sat_div(f / 99840);
          expected_results.push_back(r);
        end
      end
      ActTick: begin
        if (!ramping_q) return;
        if (wait_q > 0) begin
          wait_q = wait_q - 16'd1;
          if (wait_q > 0) return;
        end
        up = goal_q > origin_q;
        if ((up && next_q > goal_q) || (!up && next_q < goal_q)) begin
          // Start already past the target: finish without writing.
          ramping_q = 1'b0;
          resume_q = '0;
          r.status = StLast;
        end else if (next_q == guard_q && (it.display_clock_on || it.sd_clock_on)) begin
          resume_q = next_q;
          ramping_q = 1'b0;
          r.status = StAborted;
        end else begin
          word_q = next_q;
          r.pll_word = word_q;
          if (next_q == goal_q) begin
            ramping_q = 1'b0;
            resume_q = '0;
            r.status = StLast;
          end else begin
            next_q = up ? next_q + 1'b1 : next_q - 1'b1;
            wait_q = interval_q;
            r.status = StStep;
          end
        end
        expected_results.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Offer one transaction and wait until it is taken.
  task automatic send_item(input pwr_in_t it);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 5);
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_ramp(it);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == RegStepInterval) interval_q = val[15:0];
    else guard_q = val[WordW-1:0];
    @(posedge clk_i);
  endtask

  function automatic pwr_in_t make_item(input logic [1:0] a, input logic [WordW-1:0] w,
                                        input logic d, input logic s);
    pwr_in_t it;
    it.action = a;
    it.target_word = w;
    it.display_clock_on = d;
    it.sd_clock_on = s;
    return it;
  endfunction

  // Directed table. Rows with check set carry a result read straight off the
  // behavior: refusals, busy answers and a zero-frequency acceptance.
  typedef struct {
    pwr_in_t  it;
    bit       check;
    pwr_out_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(input pwr_in_t it, input bit chk, input pwr_out_t w);
    dir_row_t row;
    row.it = it;
    row.check = chk;
    row.want = w;
    dir_rows.push_back(row);
  endtask

  function automatic pwr_out_t typed_result(input logic [2:0] st, input logic [WordW-1:0] w,
                                            input logic [FreqW-1:0] f, input logic [3:0] dv);
    pwr_out_t r;
    r = '0;
    r.status = st;
    r.pll_word = w;
    r.freq_khz = f;
    r.periph_div = dv;
    r.display_div = dv;
    r.serial_rx_div = dv;
    r.hdmi_div = dv;
    r.video_div = dv;
    r.sd_div = dv;
    return r;
  endfunction

  task automatic run_directed();
    pwr_out_t nil;
    nil = '0;
    // Refusals straight after reset, with the reset guard word.
    add_row(make_item(ActRequest, 25'h1FFFFFF, 1'b0, 1'b1), 1'b1,
            typed_result(StRefused, '0, '0, 4'd0));
    add_row(make_item(ActRequest, GuardWordReset, 1'b1, 1'b0), 1'b1,
            typed_result(StRefused, '0, '0, 4'd0));
    add_row(make_item(ActTick, '0, 1'b0, 1'b0), 1'b0, nil);   // idle tick
    add_row(make_item(ActUnknown, 25'h1FFFFFF, 1'b1, 1'b1), 1'b0, nil); // unknown action
    // Divider zero gives zero frequency; the ramp runs from 0 up to 3.
    add_row(make_item(ActRequest, 25'h0000003, 1'b0, 1'b0), 1'b1,
            typed_result(StAccepted, '0, '0, 4'd0));
    add_row(make_item(ActRequest, 25'h0000003, 1'b0, 1'b0), 1'b1,
            typed_result(StBusy, '0, '0, 4'd0));
    for (int k = 0; k < 4; k++) add_row(make_item(ActTick, '0, 1'b0, 1'b0), 1'b0, nil);
    // Largest frequency: multiplier 255 over divider 1; every divider clamps.
    add_row(make_item(ActRequest, 25'h00100FF, 1'b0, 1'b0), 1'b0, nil);
    // Preload during a ramp; the ramp goes on from its next word.
    add_row(make_item(ActPreload, 25'h0000010, 1'b1, 1'b1), 1'b0, nil);
    for (int k = 0; k < 6; k++) add_row(make_item(ActTick, '0, 1'b1, 1'b0), 1'b0, nil);
    // Half bit with divider 255 and tiny multiplier.
    add_row(make_item(ActRequest, 25'h1FF0001, 1'b0, 1'b0), 1'b0, nil);
    for (int k = 0; k < 4; k++) add_row(make_item(ActTick, '0, 1'b0, 1'b0), 1'b0, nil);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it);
      if (dir_rows[i].check) begin
        if (expected_results.size() == 0 ||
            expected_results[expected_results.size()-1] != dir_rows[i].want) begin
          $display("%0t: table row %0d expected %p predicted otherwise", $time, i,
                   dir_rows[i].want);
          errors++;
        end
      end
    end
    go_idle();
  endtask

  // Random traffic: mostly ticks, with requests near the current word or the
  // guard, preloads, busy requests, unknown actions and clock enables mixed in.
  task automatic run_random(input int count, input logic [WordW-1:0] guard_hint);
    pwr_in_t it;
    logic [WordW-1:0] w;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        it = make_item(ActTick, WordW'($urandom), $urandom_range(0, 7) == 0,
                       $urandom_range(0, 9) == 0);
      end else if (pick < 85) begin
        w = WordW'(word_q + $urandom_range(0, 8) - 4);
        if ($urandom_range(0, 3) == 0) w = WordW'(guard_hint + $urandom_range(0, 4) - 2);
        if ($urandom_range(0, 4) == 0) w = WordW'($urandom);
        it = make_item(ActRequest, w, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
      end else if (pick < 95) begin
        w = ($urandom_range(0, 1) != 0) ? WordW'(guard_hint + $urandom_range(0, 4) - 2) :
                                          WordW'($urandom);
        it = make_item(ActPreload, w, 1'($urandom), 1'($urandom));
      end else begin
        it = make_item(ActUnknown, WordW'($urandom), 1'($urandom), 1'($urandom));
      end
      send_item(it);
    end
    go_idle();
  endtask

  // Compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        if (out_data_o !== expected_results[0])
          $display("%0t: mismatch expected %p actual %p", $time, expected_results[0],
                   out_data_o);
        if (out_data_o.status !== expected_results[0].status ||
            out_data_o.pll_word !== expected_results[0].pll_word ||
            out_data_o.freq_khz !== expected_results[0].freq_khz ||
            out_data_o.periph_div !== expected_results[0].periph_div ||
            out_data_o.display_div !== expected_results[0].display_div ||
            out_data_o.serial_rx_div !== expected_results[0].serial_rx_div ||
            out_data_o.hdmi_div !== expected_results[0].hdmi_div ||
            out_data_o.video_div !== expected_results[0].video_div ||
            out_data_o.sd_div !== expected_results[0].sd_div)
          errors++;
        void'(expected_results.pop_front());
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_off = 1'b0;
        @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on any channel.
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    interval_q = StepIntervalReset;
    guard_q = GuardWordReset;
    word_q = '0; goal_q = '0; origin_q = '0; resume_q = '0; next_q = '0;
    ramping_q = 1'b0; wait_q = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Interval 0 with the reset guard far away. Short directed pass.
    write_reg(RegStepInterval, 32'd0);
    run_directed();

    // Interval 1, guard near small words so aborts and resumes occur.
    write_reg(RegStepInterval, 32'd1);
    write_reg(RegGuardWord, 32'd40);
    hold_off = 1'b1;   // receiver holds off while items keep coming
    run_random(200, 25'd40);

    // Interval 3 with guard at zero; then the extremes of both registers.
    write_reg(RegStepInterval, 32'd3);
    write_reg(RegGuardWord, 32'd0);
    run_random(150, 25'd0);
    write_reg(RegStepInterval, 32'd2);
    write_reg(RegGuardWord, 32'h1FFFFFF);
    run_random(100, 25'h1FFFFFF);
    write_reg(RegStepInterval, 32'hFFFF);
    write_reg(RegGuardWord, 32'h0050180);
    run_random(40, 25'h0050180);
    // Reload both registers and run with no idling.
    write_reg(RegStepInterval, 32'd0);
    write_reg(RegGuardWord, 32'd20);
    quiet = 1'b1;
    run_random(120, 25'd20);

    stim_done = 1'b1;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
